@@ src/mfw_pkg.sv @@
// ----------------------------------------------------------------------------
// mfw_pkg: shared types and constants of the median filter window core
// Pixel and register widths, operation and register codes, reset values and
// the control bundle handed from the front end to the window stage.
// ----------------------------------------------------------------------------
package mfw_pkg;

  localparam int PIX_W         = 8;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 12;
  localparam int CFG_WIDTH_W   = 11;
  localparam int CFG_HEIGHT_W  = 12;

  localparam int DEF_WINDOW    = 3;
  localparam int DEF_MAX_WIDTH = 1024;

  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // One result issued into the window stage.
  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } mfw_issue_t;

endpackage

@@ src/mfw_line_store.sv @@
// ----------------------------------------------------------------------------
// mfw_line_store: banked line memories
// One bank per window row, selected by row modulo the window size. Each bank
// has one write port and two registered read ports: a column fetch that reads
// all banks at once and a center read for border pixels. Reads return the
// data written at the same edge.
// ----------------------------------------------------------------------------
module mfw_line_store #(
  parameter int WINDOW    = mfw_pkg::DEF_WINDOW,
  parameter int MAX_WIDTH = mfw_pkg::DEF_MAX_WIDTH
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [$clog2(WINDOW)-1:0]                  wr_bank,
  input  logic [$clog2(MAX_WIDTH)-1:0]               wr_col,
  input  logic [mfw_pkg::PIX_W-1:0]                  wr_data,
  input  logic                                       rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]               rd_col,
  input  logic [$clog2(WINDOW)-1:0]                  ctr_bank,
  input  logic [$clog2(MAX_WIDTH)-1:0]               ctr_col,
  output logic [WINDOW-1:0][mfw_pkg::PIX_W-1:0]      fetch_data,
  output logic [mfw_pkg::PIX_W-1:0]                  ctr_data
);
  import mfw_pkg::*;

  localparam int BW = $clog2(WINDOW);

  logic [WINDOW-1:0][PIX_W-1:0] ctr_bank_data;
  logic [BW-1:0]                ctr_sel_r;

  for (genvar b = 0; b < WINDOW; b++) begin : g_bank
    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] fetch_r;
    logic [PIX_W-1:0] ctr_r;
    logic             bank_wr;

    assign bank_wr = wr_en && (wr_bank == BW'(b));

    always_ff @(posedge clk) begin
      if (bank_wr) begin
        line_mem[wr_col] <= wr_data;
      end
      if (rd_en) begin
        fetch_r <= (bank_wr && (wr_col == rd_col)) ? wr_data : line_mem[rd_col];
        ctr_r   <= (bank_wr && (wr_col == ctr_col)) ? wr_data : line_mem[ctr_col];
      end
    end

    assign fetch_data[b]    = fetch_r;
    assign ctr_bank_data[b] = ctr_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ctr_sel_r <= ctr_bank;
    end
  end

  assign ctr_data = ctr_bank_data[ctr_sel_r];

endmodule

@@ src/mfw_median.sv @@
// ----------------------------------------------------------------------------
// mfw_median: rank-select median of a square window
// Every element is ranked against all others, ties broken by position, so the
// ranks form a permutation; the element whose rank is the middle one wins.
// ----------------------------------------------------------------------------
module mfw_median #(
  parameter int WINDOW = mfw_pkg::DEF_WINDOW
) (
  input  logic [WINDOW*WINDOW-1:0][mfw_pkg::PIX_W-1:0] win,
  output logic [mfw_pkg::PIX_W-1:0]                    med
);
  import mfw_pkg::*;

  localparam int N   = WINDOW * WINDOW;
  localparam int RW  = $clog2(N + 1);
  localparam int MID = N / 2;

  logic [N-1:0][RW-1:0] rank;
  logic [N-1:0]         sel;

  always_comb begin
    med = '0;
    for (int i = 0; i < N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < N; j++) begin
        if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
          rank[i] = rank[i] + RW'(1);
        end
      end
    end
    for (int i = 0; i < N; i++) begin
      sel[i] = (rank[i] == RW'(MID));
      med    = med | (sel[i] ? win[i] : '0);
    end
  end

endmodule

@@ src/mfw_window.sv @@
// ----------------------------------------------------------------------------
// mfw_window: window registers, median and result register
// Each result shifts one fetched column into the window. The median of the
// shifted window, or the center pixel for border results, goes to the output
// register, which holds while the receiver stalls.
// ----------------------------------------------------------------------------
module mfw_window #(
  parameter int WINDOW = mfw_pkg::DEF_WINDOW
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mfw_pkg::mfw_issue_t                   issue,
  input  logic [WINDOW-1:0][mfw_pkg::PIX_W-1:0] fetch_data,
  input  logic [mfw_pkg::PIX_W-1:0]             ctr_data,
  output logic                                  stage_ready,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mfw_pkg::PIX_W-1:0]             out_grey_value,
  output logic                                  out_is_border,
  output logic                                  out_frame_last
);
  import mfw_pkg::*;

  logic                                     s1_valid_r;
  logic                                     s1_border_r;
  logic                                     s1_last_r;
  logic [WINDOW-1:0][WINDOW-1:0][PIX_W-1:0] win_r;
  logic [WINDOW-1:0][WINDOW-1:0][PIX_W-1:0] win_nxt;
  logic [WINDOW*WINDOW-1:0][PIX_W-1:0]      med_in;
  logic [PIX_W-1:0]                         med;
  logic                                     out_valid_r;
  logic [PIX_W-1:0]                         grey_r;
  logic                                     border_r;
  logic                                     last_r;
  logic                                     out_can;
  logic                                     advance;

  always_comb begin
    for (int j = 0; j < WINDOW; j++) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win_nxt[j][i] = win_r[j][i+1];
      end
      win_nxt[j][WINDOW-1] = fetch_data[j];
      for (int i = 0; i < WINDOW; i++) begin
        med_in[j*WINDOW+i] = win_nxt[j][i];
      end
    end
  end

  mfw_median #(
    .WINDOW (WINDOW)
  ) u_median (
    .win (med_in),
    .med (med)
  );

  assign out_can     = !out_valid_r || out_ready;
  assign advance     = s1_valid_r && out_can;
  assign stage_ready = !s1_valid_r || out_can;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue.emit) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue.emit) begin
      s1_border_r <= issue.border;
      s1_last_r   <= issue.last;
    end
    if (advance) begin
      win_r    <= win_nxt;
      grey_r   <= s1_border_r ? ctr_data : med;
      border_r <= s1_border_r;
      last_r   <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_grey_value = grey_r;
  assign out_is_border  = border_r;
  assign out_frame_last = last_r;

endmodule

@@ src/median_filter_window_core.sv @@
// ----------------------------------------------------------------------------
// median_filter_window_core: streaming square-window median filter
// Takes red pixels in raster order and returns, per pixel, the median of its
// window, or the pixel itself when it lies within half a window of an edge.
//
// Input transactions carry an operation and a red value. A pixel is written
// to the line store; a drain, or a pixel sent after the frame is complete,
// only releases the next pending result. Results lag the input by half a
// window of rows and columns, so the last results of a frame need drains.
// Output transactions carry the grey value, a border flag and a frame-last
// flag; after the frame-last result a new frame starts.
// A released result passes the line-store read registers and the window
// stage into the output register. Throughput: one input transaction per
// cycle while the receiver takes results, set by the single fetch port per
// bank and the combinational median. Configuration writes restart the frame.
// Reset: width 640, height 480, all position counters cleared; the line
// store and window registers are not cleared and need no clearing pass.
// A stalled receiver holds the output register; one more result waits in the
// window stage, after which in_ready drops until the receiver takes one.
// ----------------------------------------------------------------------------
module median_filter_window_core #(
  parameter int WINDOW    = mfw_pkg::DEF_WINDOW,
  parameter int MAX_WIDTH = mfw_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [mfw_pkg::PIX_W-1:0]         in_red_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mfw_pkg::PIX_W-1:0]         out_grey_value,
  output logic                              out_is_border,
  output logic                              out_frame_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mfw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mfw_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mfw_pkg::*;

  localparam int HALF      = WINDOW / 2;
  localparam int FO        = WINDOW - 1 - HALF;
  localparam int BW        = $clog2(WINDOW);
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int WX        = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;
  localparam int SW        = WW + 1;
  localparam int HW        = CFG_HEIGHT_W;
  localparam int HW1       = HW + 1;
  localparam int CNT_W     = WW + HW + 1;
  localparam int RST_EW    = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_TOTAL = RST_EW * RESET_HEIGHT;
  localparam int RST_LAG   = HALF * RST_EW + HALF;

  logic [CFG_WIDTH_W-1:0]  image_width_r;
  logic [CFG_WIDTH_W-1:0]  width_nxt;
  logic [HW-1:0]           image_height_r;
  logic [HW-1:0]           height_nxt;
  logic [WW-1:0]           weff;
  logic [WW-1:0]           weff_nxt;
  logic [HW-1:0]           heff;
  logic [HW-1:0]           heff_nxt;
  logic [CNT_W-1:0]        total_r;
  logic [CNT_W-1:0]        total_nxt;
  logic [CNT_W-1:0]        lag_r;
  logic [CNT_W-1:0]        lag_nxt;

  logic [CNT_W-1:0]        n_r;
  logic [CNT_W-1:0]        n_inc;
  logic [CW-1:0]           in_col_r;
  logic [BW-1:0]           in_bank_r;
  logic [CNT_W-1:0]        k_r;
  logic [CNT_W-1:0]        kl_r;
  logic [CW-1:0]           c_r;
  logic [HW-1:0]           r_r;
  logic [BW-1:0]           cb_r;

  logic                    cfg_wr;
  logic                    accept;
  logic                    is_pixel;
  logic                    frame_done;
  logic                    do_write;
  logic                    emit_ok;
  logic                    emit;
  logic                    in_col_wrap;
  logic                    out_col_wrap;
  logic [SW-1:0]           fetch_sum;
  logic                    fetch_wrap;
  logic [SW-1:0]           fetch_pos;
  logic [CW-1:0]           fetch_col;
  logic [SW-1:0]           edge_sum;
  logic                    border;
  logic                    last;
  mfw_issue_t              issue;
  logic [WINDOW-1:0][PIX_W-1:0] fetch_data;
  logic [PIX_W-1:0]        ctr_data;
  logic                    stage_ready;

  function automatic logic [WW-1:0] eff_width(input logic [CFG_WIDTH_W-1:0] v);
    logic [WX-1:0] vx;
    vx = WX'(v);
    if (v == '0) begin
      return WW'(1);
    end else if (vx > WX'(MAX_WIDTH)) begin
      return WW'(MAX_WIDTH);
    end
    return vx[WW-1:0];
  endfunction

  function automatic logic [HW-1:0] eff_height(input logic [HW-1:0] v);
    return (v == '0) ? HW'(1) : v;
  endfunction

  function automatic logic [BW-1:0] bank_inc(input logic [BW-1:0] b);
    return (b == BW'(WINDOW - 1)) ? '0 : b + BW'(1);
  endfunction

  // Configuration; the frame size products are formed from the values that
  // take effect at the next edge.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign width_nxt  = (cfg_wr && (cfg_index == CFG_IMAGE_WIDTH)) ?
                      cfg_data[CFG_WIDTH_W-1:0] : image_width_r;
  assign height_nxt = (cfg_wr && (cfg_index == CFG_IMAGE_HEIGHT)) ?
                      cfg_data[HW-1:0] : image_height_r;
  assign weff_nxt   = eff_width(width_nxt);
  assign heff_nxt   = eff_height(height_nxt);
  assign total_nxt  = CNT_W'(weff_nxt) * CNT_W'(heff_nxt);
  assign lag_nxt    = CNT_W'(weff_nxt) * CNT_W'(HALF) + CNT_W'(HALF);
  assign weff       = eff_width(image_width_r);
  assign heff       = eff_height(image_height_r);

  // Input side.
  assign in_ready    = stage_ready;
  assign accept      = in_valid && in_ready;
  assign is_pixel    = (in_op == OP_PIXEL);
  assign frame_done  = (n_r >= total_r);
  assign n_inc       = n_r + CNT_W'(1);
  assign do_write    = accept && is_pixel && !frame_done;
  assign emit_ok     = (is_pixel && !frame_done) ?
                       ((n_inc >= total_r) || (n_r >= kl_r)) : frame_done;
  assign emit        = accept && emit_ok;
  assign in_col_wrap = ((WW'(in_col_r) + WW'(1)) >= weff);

  // Output side. The column fetched for result k is the one FO pixels ahead
  // in raster order, so the window holds the right columns once it reaches a
  // pixel that is not on the border.
  assign fetch_sum    = SW'(c_r) + SW'(FO);
  assign fetch_wrap   = (fetch_sum >= SW'(weff));
  assign fetch_pos    = fetch_wrap ? (fetch_sum - SW'(weff)) : fetch_sum;
  assign fetch_col    = fetch_pos[CW-1:0];
  assign edge_sum     = SW'(c_r) + SW'(HALF);
  assign border       = !((r_r >= HW'(HALF)) &&
                          ((HW1'(r_r) + HW1'(HALF)) < HW1'(heff)) &&
                          (SW'(c_r) >= SW'(HALF)) &&
                          (edge_sum < SW'(weff)));
  assign last         = ((k_r + CNT_W'(1)) >= total_r);
  assign out_col_wrap = ((WW'(c_r) + WW'(1)) >= weff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= CFG_WIDTH_W'(RESET_WIDTH);
      image_height_r <= HW'(RESET_HEIGHT);
      total_r        <= CNT_W'(RST_TOTAL);
      lag_r          <= CNT_W'(RST_LAG);
      n_r            <= '0;
      in_col_r       <= '0;
      in_bank_r      <= '0;
      k_r            <= '0;
      kl_r           <= CNT_W'(RST_LAG);
      c_r            <= '0;
      r_r            <= '0;
      cb_r           <= '0;
    end else begin
      image_width_r  <= width_nxt;
      image_height_r <= height_nxt;
      total_r        <= total_nxt;
      lag_r          <= lag_nxt;
      if (cfg_wr || (emit && last)) begin
        // A register write or the end of a frame restarts every position.
        n_r       <= '0;
        in_col_r  <= '0;
        in_bank_r <= '0;
        k_r       <= '0;
        kl_r      <= cfg_wr ? lag_nxt : lag_r;
        c_r       <= '0;
        r_r       <= '0;
        cb_r      <= '0;
      end else begin
        if (do_write) begin
          n_r <= n_inc;
          if (in_col_wrap) begin
            in_col_r  <= '0;
            in_bank_r <= bank_inc(in_bank_r);
          end else begin
            in_col_r <= in_col_r + CW'(1);
          end
        end
        if (emit) begin
          k_r  <= k_r + CNT_W'(1);
          kl_r <= kl_r + CNT_W'(1);
          if (out_col_wrap) begin
            c_r  <= '0;
            r_r  <= r_r + HW'(1);
            cb_r <= bank_inc(cb_r);
          end else begin
            c_r <= c_r + CW'(1);
          end
        end
      end
    end
  end

  mfw_line_store #(
    .WINDOW    (WINDOW),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk        (clk),
    .wr_en      (do_write),
    .wr_bank    (in_bank_r),
    .wr_col     (in_col_r),
    .wr_data    (in_red_value),
    .rd_en      (emit),
    .rd_col     (fetch_col),
    .ctr_bank   (cb_r),
    .ctr_col    (c_r),
    .fetch_data (fetch_data),
    .ctr_data   (ctr_data)
  );

  assign issue.emit   = emit;
  assign issue.border = border;
  assign issue.last   = last;

  mfw_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .issue          (issue),
    .fetch_data     (fetch_data),
    .ctr_data       (ctr_data),
    .stage_ready    (stage_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_grey_value (out_grey_value),
    .out_is_border  (out_is_border),
    .out_frame_last (out_frame_last)
  );

  // The release threshold must track the result count exactly.
  a_lag_track: assert property (@(posedge clk) disable iff (!rst_n)
    kl_r == (k_r + lag_r))
    else $error("release threshold out of step with result count");

  // Results never overtake the pixels they are taken from.
  a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= n_r)
    else $error("result count ahead of input count");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (WW'(c_r) < weff) && (WW'(in_col_r) < weff))
    else $error("column counter beyond image width");

endmodule
